FILE: hdl/rcm_pkg.sv
// Shared types, constants and helper functions for the wing channel mixer.
package rcm_pkg;

    localparam int VAL_W = 24;          // internal signed value width
    localparam int FAC_W = 9;           // percent factor width
    localparam int CH_W = 12;           // channel field width
    localparam int NUM_MIX = 10;
    localparam int NUM_CH = 8;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int PCT_W = 40;

    localparam int DEF_CHANNEL_LIMIT = 1250;
    localparam int DEF_CHANNEL_PER_PERCENT = 10;

    // divide by 100 via reciprocal: q = (|p| * RECIP) >> RECIP_SHIFT, exact for |p| < 2**23
    localparam int MAG_W = 23;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int RECIP_SHIFT = 30;
    localparam int PCT_SCALE = 100;

    // cross mix numbers
    localparam int XM_AIL_RUD = 0;
    localparam int XM_AIL_FLP = 1;
    localparam int XM_SPL_AIL = 2;
    localparam int XM_SPL_FLP = 3;
    localparam int XM_SPL_ELV = 4;
    localparam int XM_FLP_AIL = 5;
    localparam int XM_FLP_ELV = 6;
    localparam int XM_ELV_AIL = 7;
    localparam int XM_ELV_FLP = 8;
    localparam int XM_RUD_ELV = 9;

    // channel slots
    localparam int CH_AIL = 0;
    localparam int CH_AIL2 = 1;
    localparam int CH_ELV = 2;
    localparam int CH_RUD = 3;
    localparam int CH_FLP = 4;
    localparam int CH_FLP2 = 5;
    localparam int CH_SPL = 6;
    localparam int CH_SPL2 = 7;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [FAC_W-1:0] t_fac;

    typedef enum logic [1:0] {
        WING_NORMAL = 2'd0,
        WING_DELTA  = 2'd1,
        WING_VTAIL  = 2'd2,
        WING_NONE   = 2'd3
    } t_wing;

    typedef enum logic [2:0] {
        REG_WING_MODE = 3'd0,
        REG_DIFF_PCT  = 3'd1,
        REG_MIX_PCT_A = 3'd2,
        REG_MIX_PCT_B = 3'd3,
        REG_MIX_OFF_A = 3'd4,
        REG_MIX_OFF_B = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_wing              wing_mode;
        logic signed [7:0]  diff_pct;
        logic [PCT_W-1:0]   mix_pct_a;
        logic [PCT_W-1:0]   mix_pct_b;
        logic [PCT_W-1:0]   mix_off_a;
        logic [PCT_W-1:0]   mix_off_b;
    } t_cfg;

    typedef struct packed {
        logic signed [CH_W-1:0] ail_in;
        logic signed [CH_W-1:0] ail2_in;
        logic signed [CH_W-1:0] elv_in;
        logic signed [CH_W-1:0] rud_in;
        logic signed [CH_W-1:0] flp_in;
        logic signed [CH_W-1:0] spl_in;
        logic signed [CH_W-1:0] ail_trim;
        logic                   diff_on;
        logic [NUM_MIX-1:0]     mix_on;
    } t_in_word;

    typedef struct packed {
        logic signed [CH_W-1:0] ail_out;
        logic signed [CH_W-1:0] ail2_out;
        logic signed [CH_W-1:0] elv_out;
        logic signed [CH_W-1:0] rud_out;
        logic signed [CH_W-1:0] flp_out;
        logic signed [CH_W-1:0] flp2_out;
        logic signed [CH_W-1:0] spl_out;
        logic signed [CH_W-1:0] spl2_out;
    } t_out_word;

    typedef struct packed {
        t_val first;
        t_val second;
    } t_pair;

    function automatic logic signed [7:0] byte_of(logic [PCT_W-1:0] a, logic [PCT_W-1:0] b,
                                                 int k);
        logic signed [7:0] v;
        if (k < 5) v = a[8*k +: 8];
        else       v = b[8*(k-5) +: 8];
        return v;
    endfunction

    function automatic t_val clamp(t_val v, t_val lim);
        t_val o;
        if (v > lim)       o = lim;
        else if (v < -lim) o = -lim;
        else               o = v;
        return o;
    endfunction

    // 100 - |diff|
    function automatic t_fac diff_factor(logic signed [7:0] p);
        t_fac ap;
        ap = (p < 0) ? -FAC_W'(p) : FAC_W'(p);
        return t_fac'(FAC_W'(PCT_SCALE)) - ap;
    endfunction

    // differential split of x against trim t, r = trunc((x-t)*factor/100)
    function automatic t_pair split(t_val x, t_val t, t_val r, logic on, logic pos);
        t_pair o;
        t_val  d;
        d = x - t;
        if (!on) begin
            o.first = x;
            o.second = -x;
        end else if (pos == (d > 0)) begin
            o.first = x;
            o.second = -t - r;
        end else begin
            o.first = t + r;
            o.second = -x;
        end
        return o;
    endfunction

endpackage

FILE: hdl/rcm_regs.sv
// Configuration register file behind the APB port.
module rcm_regs
    import rcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (idx)
                REG_WING_MODE: r_cfg.wing_mode <= t_wing'(pwdata[1:0]);
                REG_DIFF_PCT:  r_cfg.diff_pct <= pwdata[7:0];
                REG_MIX_PCT_A: r_cfg.mix_pct_a <= pwdata[PCT_W-1:0];
                REG_MIX_PCT_B: r_cfg.mix_pct_b <= pwdata[PCT_W-1:0];
                REG_MIX_OFF_A: r_cfg.mix_off_a <= pwdata[PCT_W-1:0];
                REG_MIX_OFF_B: r_cfg.mix_off_b <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WING_MODE: prdata = DATA_W'(r_cfg.wing_mode);
            REG_DIFF_PCT:  prdata = DATA_W'($unsigned(r_cfg.diff_pct));
            REG_MIX_PCT_A: prdata = DATA_W'(r_cfg.mix_pct_a);
            REG_MIX_PCT_B: prdata = DATA_W'(r_cfg.mix_pct_b);
            REG_MIX_OFF_A: prdata = DATA_W'(r_cfg.mix_off_a);
            REG_MIX_OFF_B: prdata = DATA_W'(r_cfg.mix_off_b);
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: hdl/rcm_scale.sv
// Three-stage lane: q = trunc(a * b / 100), divide done by reciprocal multiply.
module rcm_scale
    import rcm_pkg::*;
(
    input  logic i_clk,
    input  t_val i_a,
    input  t_fac i_b,
    output t_val o_q
);

    logic signed [VAL_W+FAC_W-1:0] n_prod;
    t_val                          r_prod;
    logic [MAG_W-1:0]              n_mag;
    logic [MAG_W+RECIP_W-1:0]      r_scaled;
    logic                          r_neg;
    t_val                          n_q;
    t_val                          r_q;

    assign n_prod = i_a * i_b;
    assign n_mag = (r_prod < 0) ? MAG_W'(-r_prod) : MAG_W'(r_prod);

    always_comb begin
        n_q = t_val'(VAL_W'(r_scaled[MAG_W+RECIP_W-1:RECIP_SHIFT]));
        if (r_neg) n_q = -n_q;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= VAL_W'(n_prod);
        r_scaled <= (MAG_W+RECIP_W)'(n_mag) * (MAG_W+RECIP_W)'(RECIP);
        r_neg <= r_prod < 0;
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: hdl/rc_wing_channel_mixer.sv
// Top level of the wing channel mixer: input staging, wing mix, cross mixes, clamps.
//
//  port group      | direction | handshake
//  ----------------+-----------+-------------------------------------------
//  i_in            | in        | taken when start is high and busy is low
//  o_res           | out       | one cycle, marked by o_res_valid
//  APB (psel ...)  | in/out    | write on psel & penable & pwrite & pready
//
// The pipeline runs through the input register, source prep, 3-stage divide lanes,
// wing mix, a 3-stage lane for the aileron-to-flap differential, final sum.
// One word enters per cycle; busy stays low. Synchronous reset clears the
// valid pipeline and the config registers. The receiver cannot stall.
module rc_wing_channel_mixer
    import rcm_pkg::*;
#(
    parameter int CHANNEL_LIMIT = DEF_CHANNEL_LIMIT,
    parameter int CHANNEL_PER_PERCENT = DEF_CHANNEL_PER_PERCENT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_word          i_in,
    output logic              o_res_valid,
    output t_out_word         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int LAT = 10;

    typedef struct {
        t_val     c[NUM_CH];
        t_val     m[NUM_MIX];
        t_in_word w;
    } t_mid;

    t_cfg     cfg;
    t_val     lim;
    t_fac     fac;
    logic     pos;

    logic [LAT:1] r_v;
    t_in_word r_s1;
    t_in_word r_s2, r_s3, r_s4, r_s5;
    t_val     r_x[NUM_MIX];
    t_val     r_d0;
    t_val     n_x[NUM_MIX];
    t_val     q[NUM_MIX];
    t_val     q0;
    t_val     r_d1;
    t_val     r1;
    t_mid     n_mid, r_m6, r_m7, r_m8, r_m9;
    t_val     n_c[NUM_CH];
    t_out_word r_out;

    rcm_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    assign busy = 1'b0;
    assign lim = t_val'(CHANNEL_LIMIT);
    assign fac = diff_factor(cfg.diff_pct);
    assign pos = cfg.diff_pct > 0;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LAT-1:1], start && !busy};
        end
    end

    // source prep: x = src - off * per-percent
    always_comb begin
        t_val src;
        t_val off;
        for (int k = 0; k < NUM_MIX; k++) begin
            unique case (k)
                XM_AIL_RUD, XM_AIL_FLP:             src = t_val'(r_s1.ail_in);
                XM_SPL_AIL, XM_SPL_FLP, XM_SPL_ELV: src = t_val'(r_s1.spl_in);
                XM_FLP_AIL, XM_FLP_ELV:             src = t_val'(r_s1.flp_in);
                XM_ELV_AIL, XM_ELV_FLP:             src = t_val'(r_s1.elv_in);
                default: src = (r_s1.rud_in < 0) ? -t_val'(r_s1.rud_in)
                                                 : t_val'(r_s1.rud_in);
            endcase
            off = t_val'(byte_of(cfg.mix_off_a, cfg.mix_off_b, k));
            n_x[k] = src - off * t_val'(CHANNEL_PER_PERCENT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= i_in;
        r_x <= n_x;
        r_d0 <= t_val'(r_s1.ail_in) - t_val'(r_s1.ail_trim);
        r_s2 <= r_s1;
        r_s3 <= r_s2;
        r_s4 <= r_s3;
        r_s5 <= r_s4;
    end

    for (genvar k = 0; k < NUM_MIX; k++) begin : g_mix
        rcm_scale u_scale (
            .i_clk(i_clk),
            .i_a  (r_x[k]),
            .i_b  (t_fac'(byte_of(cfg.mix_pct_a, cfg.mix_pct_b, k))),
            .o_q  (q[k])
        );
    end

    rcm_scale u_wing_diff (
        .i_clk(i_clk),
        .i_a  (r_d0),
        .i_b  (fac),
        .o_q  (q0)
    );

    // wing mix and first clamp
    always_comb begin
        t_pair fs;
        t_val  ail, elv, rud, trim;
        logic  on;
        ail = t_val'(r_s5.ail_in);
        elv = t_val'(r_s5.elv_in);
        rud = t_val'(r_s5.rud_in);
        trim = t_val'(r_s5.ail_trim);
        on = r_s5.diff_on && (cfg.diff_pct != 0);
        fs = split(ail, trim, q0, on, pos);
        n_mid.c[CH_AIL] = ail;
        n_mid.c[CH_AIL2] = t_val'(r_s5.ail2_in);
        n_mid.c[CH_ELV] = elv;
        n_mid.c[CH_RUD] = rud;
        n_mid.c[CH_FLP] = t_val'(r_s5.flp_in);
        n_mid.c[CH_FLP2] = t_val'(r_s5.flp_in);
        n_mid.c[CH_SPL] = t_val'(r_s5.spl_in);
        n_mid.c[CH_SPL2] = t_val'(r_s5.spl_in);
        unique case (cfg.wing_mode)
            WING_DELTA: begin
                n_mid.c[CH_AIL] = elv + fs.first;
                n_mid.c[CH_ELV] = elv + fs.second;
            end
            WING_NORMAL, WING_VTAIL: begin
                if (cfg.wing_mode == WING_VTAIL) begin
                    n_mid.c[CH_RUD] = elv + rud;
                    n_mid.c[CH_ELV] = elv - rud;
                end
                n_mid.c[CH_AIL] = fs.first;
                n_mid.c[CH_AIL2] = fs.second;
            end
            WING_NONE: ;
        endcase
        for (int i = 0; i < NUM_CH; i++) n_mid.c[i] = clamp(n_mid.c[i], lim);
        n_mid.m = q;
        n_mid.w = r_s5;
    end

    always_ff @(posedge i_clk) begin
        r_m6 <= n_mid;
        r_d1 <= q[XM_AIL_FLP] - t_val'(r_s5.ail_trim);
        r_m7 <= r_m6;
        r_m8 <= r_m7;
        r_m9 <= r_m8;
    end

    rcm_scale u_flap_diff (
        .i_clk(i_clk),
        .i_a  (r_d1),
        .i_b  (fac),
        .o_q  (r1)
    );

    // cross mixes and final clamp
    always_comb begin
        t_val  m[NUM_MIX];
        t_pair fs;
        logic  on, delta, vtail;
        on = r_m9.w.diff_on && (cfg.diff_pct != 0);
        delta = cfg.wing_mode == WING_DELTA;
        vtail = cfg.wing_mode == WING_VTAIL;
        for (int k = 0; k < NUM_MIX; k++) m[k] = r_m9.w.mix_on[k] ? r_m9.m[k] : '0;
        fs = split(r_m9.m[XM_AIL_FLP], t_val'(r_m9.w.ail_trim), r1, on, pos);
        if (!r_m9.w.mix_on[XM_AIL_FLP]) fs = '0;
        n_c = r_m9.c;
        n_c[CH_RUD] = n_c[CH_RUD] + m[XM_AIL_RUD];
        if (vtail) n_c[CH_ELV] = n_c[CH_ELV] - m[XM_AIL_RUD];
        n_c[CH_FLP] = n_c[CH_FLP] + fs.first + m[XM_SPL_FLP] + m[XM_ELV_FLP];
        n_c[CH_FLP2] = n_c[CH_FLP2] + fs.second + m[XM_SPL_FLP] + m[XM_ELV_FLP];
        begin
            t_val to_ail, to_elv;
            to_ail = m[XM_SPL_AIL] + m[XM_FLP_AIL] + m[XM_ELV_AIL];
            to_elv = m[XM_SPL_ELV] + m[XM_FLP_ELV] + m[XM_RUD_ELV];
            n_c[CH_AIL] = n_c[CH_AIL] + to_ail;
            n_c[CH_AIL2] = n_c[CH_AIL2] + to_ail;
            if (delta) n_c[CH_ELV] = n_c[CH_ELV] + to_ail;
            n_c[CH_ELV] = n_c[CH_ELV] + to_elv;
            if (vtail)      n_c[CH_RUD] = n_c[CH_RUD] + to_elv;
            else if (delta) n_c[CH_AIL] = n_c[CH_AIL] + to_elv;
        end
        for (int i = 0; i < NUM_CH; i++) n_c[i] = clamp(n_c[i], lim);
    end

    always_ff @(posedge i_clk) begin
        r_out.ail_out <= n_c[CH_AIL][CH_W-1:0];
        r_out.ail2_out <= n_c[CH_AIL2][CH_W-1:0];
        r_out.elv_out <= n_c[CH_ELV][CH_W-1:0];
        r_out.rud_out <= n_c[CH_RUD][CH_W-1:0];
        r_out.flp_out <= n_c[CH_FLP][CH_W-1:0];
        r_out.flp2_out <= n_c[CH_FLP2][CH_W-1:0];
        r_out.spl_out <= n_c[CH_SPL][CH_W-1:0];
        r_out.spl2_out <= n_c[CH_SPL2][CH_W-1:0];
    end

    assign o_res = r_out;
    assign o_res_valid = r_v[LAT];

    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start, LAT))
        else $error("result word without matching start");
    a_spl_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.spl2_out == o_res.spl_out)
        else $error("spoiler copy differs");

endmodule

FILE: tb/rcm_checker.sv
// Checker for the wing channel mixer: tracks config writes, predicts each frame, compares.
module rcm_checker
    import rcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_in_word          i_in,
    input  logic              o_res_valid,
    input  t_out_word         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_fail_cnt,
    output int                o_pending
);

    localparam longint LIMIT = DEF_CHANNEL_LIMIT;
    localparam longint PER_PCT = DEF_CHANNEL_PER_PERCENT;

    t_wing             wing;
    logic signed [7:0] diff;
    logic [PCT_W-1:0]  pct_a, pct_b, off_a, off_b;
    t_out_word         frames_due[$];
    int                fails;

    initial fails = 0;

    function automatic longint cfg_byte(logic [PCT_W-1:0] a, logic [PCT_W-1:0] b, int k);
        logic signed [7:0] v;
        if (k < 5) v = a[8*k +: 8];
        else       v = b[8*(k-5) +: 8];
        return longint'(v);
    endfunction

    function automatic longint cross_term(longint src, int k);
        return (src - cfg_byte(off_a, off_b, k) * PER_PCT) * cfg_byte(pct_a, pct_b, k) / 100;
    endfunction

    function automatic void diff_split(longint x, longint t, bit on,
                                       output longint f, output longint s);
        longint p, d, ap, r;
        p = longint'(diff);
        if (!on) begin
            f = x;
            s = -x;
        end else begin
            d = x - t;
            ap = (p < 0) ? -p : p;
            r = d * (100 - ap) / 100;
            if ((p > 0) == (d > 0)) begin
                f = x;
                s = -t - r;
            end else begin
                f = t + r;
                s = -x;
            end
        end
    endfunction

    function automatic void clamp_frame(ref longint c[8]);
        for (int i = 0; i < 8; i++) begin
            if (c[i] > LIMIT) c[i] = LIMIT;
            else if (c[i] < -LIMIT) c[i] = -LIMIT;
        end
    endfunction

    function automatic t_out_word mix_frame(t_in_word w);
        longint    c[8];
        longint    ail, elv, rud, flp, spl, trim, f, s, m;
        bit        on, dlt, vt;
        t_out_word res;
        ail = w.ail_in; elv = w.elv_in; rud = w.rud_in;
        flp = w.flp_in; spl = w.spl_in; trim = w.ail_trim;
        on = w.diff_on && (diff != 0);
        dlt = (wing == WING_DELTA);
        vt = (wing == WING_VTAIL);
        c[CH_AIL] = ail; c[CH_AIL2] = w.ail2_in; c[CH_ELV] = elv; c[CH_RUD] = rud;
        c[CH_FLP] = flp; c[CH_FLP2] = flp; c[CH_SPL] = spl; c[CH_SPL2] = spl;
        if (dlt) begin
            diff_split(ail, trim, on, f, s);
            c[CH_AIL] = elv + f;
            c[CH_ELV] = elv + s;
        end else if (wing != WING_NONE) begin
            if (vt) begin
                c[CH_RUD] = elv + rud;
                c[CH_ELV] = elv - rud;
            end
            diff_split(ail, trim, on, f, s);
            c[CH_AIL] = f;
            c[CH_AIL2] = s;
        end
        clamp_frame(c);
        for (int k = 0; k < NUM_MIX; k++) begin
            if (w.mix_on[k]) begin
                case (k)
                    XM_AIL_RUD: begin
                        m = cross_term(ail, k);
                        c[CH_RUD] += m;
                        if (vt) c[CH_ELV] -= m;
                    end
                    XM_AIL_FLP: begin
                        // differential is applied to the mixed value too
                        m = cross_term(ail, k);
                        diff_split(m, trim, on, f, s);
                        c[CH_FLP] += f;
                        c[CH_FLP2] += s;
                    end
                    XM_SPL_FLP, XM_ELV_FLP: begin
                        m = cross_term(k == XM_SPL_FLP ? spl : elv, k);
                        c[CH_FLP] += m;
                        c[CH_FLP2] += m;
                    end
                    XM_SPL_AIL, XM_FLP_AIL, XM_ELV_AIL: begin
                        m = cross_term(k == XM_SPL_AIL ? spl : (k == XM_FLP_AIL ? flp : elv), k);
                        c[CH_AIL] += m;
                        c[CH_AIL2] += m;
                        if (dlt) c[CH_ELV] += m;
                    end
                    default: begin
                        m = cross_term(k == XM_SPL_ELV ? spl :
                                       (k == XM_FLP_ELV ? flp : (rud < 0 ? -rud : rud)), k);
                        c[CH_ELV] += m;
                        if (vt) c[CH_RUD] += m;
                        else if (dlt) c[CH_AIL] += m;
                    end
                endcase
            end
        end
        clamp_frame(c);
        for (int i = 0; i < NUM_CH; i++)
            res[NUM_CH*CH_W-1-CH_W*i -: CH_W] = c[i][CH_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        string     names[8];
        logic [CH_W-1:0] e, a;
        names = '{"ail_out", "ail2_out", "elv_out", "rud_out",
                  "flp_out", "flp2_out", "spl_out", "spl2_out"};
        if (!i_rst_n) begin
            wing <= WING_NORMAL;
            diff <= '0;
            pct_a <= '0; pct_b <= '0; off_a <= '0; off_b <= '0;
        end else begin
            if (o_res_valid) begin
                if (frames_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    want = frames_due.pop_front();
                    for (int i = 0; i < NUM_CH; i++) begin
                        e = want[NUM_CH*CH_W-1-CH_W*i -: CH_W];
                        a = o_res[NUM_CH*CH_W-1-CH_W*i -: CH_W];
                        if (e !== a) begin
                            $error("%s: expected %0d, got %0d", names[i],
                                   $signed(e), $signed(a));
                            fails++;
                        end
                    end
                end
            end
            if (start && !busy) frames_due.push_back(mix_frame(i_in));
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
                case (paddr[ADDR_W-1:3])
                    REG_WING_MODE: wing <= t_wing'(pwdata[1:0]);
                    REG_DIFF_PCT:  diff <= pwdata[7:0];
                    REG_MIX_PCT_A: pct_a <= pwdata[PCT_W-1:0];
                    REG_MIX_PCT_B: pct_b <= pwdata[PCT_W-1:0];
                    REG_MIX_OFF_A: off_a <= pwdata[PCT_W-1:0];
                    REG_MIX_OFF_B: off_b <= pwdata[PCT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= frames_due.size();
        o_fail_cnt <= fails;
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the wing channel mixer: clock, reset, stimulus and verdict.
module tb_top;
    import rcm_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_word          i_in = '0;
    logic              o_res_valid;
    t_out_word         o_res;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_cnt, pending;
    int                burst_left;

    always #4 i_clk = ~i_clk;

    rc_wing_channel_mixer u_top (.*);

    rcm_checker u_chk (.i_clk, .i_rst_n, .start, .busy, .i_in, .o_res_valid, .o_res,
                       .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
                       .o_fail_cnt(fail_cnt), .o_pending(pending));

    initial begin
        #(8 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic reg_write(int idx, logic [DATA_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (14) @(posedge i_clk);
    endtask

    // one word, start held across back-to-back words inside a burst
    task automatic send_word(t_in_word w);
        start <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (--burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [CH_W-1:0] rand_ch();
        case ($urandom_range(0, 9))
            0: return CH_W'($urandom);
            1: return CH_W'(1250);
            2: return -CH_W'(1250);
            default: return CH_W'($urandom_range(0, 2500) - 1250);
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.ail_in = rand_ch(); w.ail2_in = rand_ch(); w.elv_in = rand_ch();
        w.rud_in = rand_ch(); w.flp_in = rand_ch(); w.spl_in = rand_ch();
        w.ail_trim = ($urandom_range(0, 3) == 0) ? '0 : rand_ch();
        w.diff_on = 1'($urandom);
        w.mix_on = NUM_MIX'($urandom);
        return w;
    endfunction

    function automatic logic [PCT_W-1:0] rand_bytes(int flavor);
        logic [PCT_W-1:0] v;
        for (int k = 0; k < 5; k++) begin
            case (flavor)
                0: v[8*k +: 8] = 8'h7f;
                1: v[8*k +: 8] = 8'h80;
                2: v[8*k +: 8] = 8'($urandom_range(0, 200) - 100);
                default: v[8*k +: 8] = 8'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic set_config(int wm, int dp, int flavor);
        reg_write(REG_WING_MODE, DATA_W'($urandom) & ~64'h3 | DATA_W'(wm));
        reg_write(REG_DIFF_PCT, DATA_W'(8'(dp)));
        reg_write(REG_MIX_PCT_A, {24'($urandom), rand_bytes(flavor)});
        reg_write(REG_MIX_PCT_B, {24'd0, rand_bytes(flavor)});
        reg_write(REG_MIX_OFF_A, {24'd0, rand_bytes(flavor == 0 ? 1 : flavor)});
        reg_write(REG_MIX_OFF_B, {24'($urandom), rand_bytes(flavor == 1 ? 0 : flavor)});
    endtask

    initial begin
        t_in_word w;
        int       dps[6];
        dps = '{0, 100, -100, 127, -128, 37};
        burst_left = 4;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, then extremes under each wing mode
        for (int wm = 0; wm < 4; wm++) begin
            if (wm != 0) set_config(wm, (wm == 2) ? -100 : 100, wm - 1);
            w = '0;
            w.diff_on = 1'b1;
            w.mix_on = '1;
            send_word(w);
            w.ail_in = 12'h7ff; w.ail2_in = 12'h800; w.elv_in = 12'h7ff;
            w.rud_in = 12'h800; w.flp_in = 12'h7ff; w.spl_in = 12'h800;
            w.ail_trim = 12'h800;
            send_word(w);
            w = ~w;
            send_word(w);
            w.ail_in = 12'd1250; w.ail_trim = -12'sd1250; w.elv_in = -12'sd1250;
            w.mix_on = 10'b10_0000_0011;
            send_word(w);
            w.ail_in = -12'sd300; w.ail_trim = 12'd200; w.diff_on = 1'b0;
            send_word(w);
            wait_idle();
        end
        // write to an unused address must be ignored
        reg_write(6, '1);

        for (int ph = 0; ph < 8; ph++) begin
            set_config($urandom_range(0, 3), (ph < 6) ? dps[ph] : $urandom_range(0, 255),
                       (ph < 2) ? ph : $urandom_range(2, 3));
            for (int n = 0; n < 160; n++) begin
                send_word(rand_word());
                if (ph == 3 && n == 80) wait_idle();
            end
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hdl/rcm_pkg.sv
hdl/rcm_regs.sv
hdl/rcm_scale.sv
hdl/rc_wing_channel_mixer.sv
tb/rcm_checker.sv
tb/tb_top.sv
